@@ sv/c816ld_pkg.sv @@
// Shared types, constants and the opcode mode table for the 65816 length decoder.
// Used by every module of the block; depends on nothing.
package c816ld_pkg;

  // Mode table entry: [1:0] base operand bytes, [5] +1 when A is 16 bit,
  // [4] +1 when X/Y is 16 bit, [8] relative target, [9] absolute-like target
  localparam logic [9:0] M_IMP = 10'h000;
  localparam logic [9:0] M_D1  = 10'h001;
  localparam logic [9:0] M_D2  = 10'h002;
  localparam logic [9:0] M_MM  = 10'h021;
  localparam logic [9:0] M_XX  = 10'h011;
  localparam logic [9:0] M_R1  = 10'h101;
  localparam logic [9:0] M_R2  = 10'h102;
  localparam logic [9:0] M_T1  = 10'h201;
  localparam logic [9:0] M_T2  = 10'h202;
  localparam logic [9:0] M_T3  = 10'h203;

  localparam int ROM_ACC_BIT = 5;
  localparam int ROM_IDX_BIT = 4;
  localparam int ROM_REL_BIT = 8;
  localparam int ROM_ABS_BIT = 9;

  localparam logic [9:0] MODE_ROM [256] = '{
    M_T1,M_D1,M_T1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_T2,M_D1,M_T3,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_IMP,M_D1,M_T1,M_D1,M_D2,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D2,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T3,M_T2,M_T2,M_T3,
    M_IMP,M_D1,M_R2,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_R2,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_XX,M_D1,M_XX,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_XX,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_D2,M_T2,M_T2,M_T3,
    M_XX,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1,M_D1, M_IMP,M_MM,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3,
    M_R1,M_D1,M_D1,M_D1,M_T2,M_D1,M_D1,M_D1, M_IMP,M_T2,M_IMP,M_IMP,M_T2,M_T2,M_T2,M_T3
  };

  // Opcodes that change the width flags
  localparam logic [7:0] OP_REP = 8'hC2;
  localparam logic [7:0] OP_SEP = 8'hE2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK_WIDTH = 8'd0,
    CFG_START_ACC   = 8'd1,
    CFG_START_IDX   = 8'd2,
    CFG_START_ADDR  = 8'd3
  } cfg_reg_t;

  localparam int ADDR_W  = 24;
  localparam int ODATA_W = 88;

  // Queue between decoder and target unit
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration write
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
  } cfg_wr_t;

  // One completed instruction
  typedef struct packed {
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        oplen;
    logic [ADDR_W-1:0] arg;
    logic              rel;
    logic              absl;
  } instr_rec_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/cpu65816_length_and_target_decoder_top.sv @@
// 65816 instruction length and target decoder. One code byte is taken per
// cycle on in_*, in every cycle as long as the two-entry queue between the
// decoder and the target unit has room. Each completed instruction gives one
// item on out_*: its record is written into the queue as its last byte is
// taken, and the target adder and output register load from the queue once
// the output register is free; one result per cycle can leave while
// out_tready is high. A stalled output fills the queue and then drops
// in_tready. Configuration writes take effect at once and are accepted in
// every cycle; they are meant for times when no instruction is in flight.
// Depends on c816ld_pkg, c816ld_front, c816ld_fifo and c816ld_back.
module cpu65816_length_and_target_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] code_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [7:0] opcode, [31:8] instr_address, [34:32] instr_length,
  // [58:35] operand_value, [82:59] target_address, [87:83] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,
  // out_tuser: [0] has_target
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  c816ld_pkg::cfg_wr_t    cfg_wr;
  c816ld_pkg::instr_rec_t push_rec;
  c816ld_pkg::instr_rec_t pop_rec;
  c816ld_pkg::q_stat_t    stat;
  logic                   push;
  logic                   pop;
  logic                   byte_fire;

  // Handshakes
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;
  assign in_tready    = !stat.full;
  assign byte_fire    = in_tvalid && in_tready;

  c816ld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .byte_fire (byte_fire),
    .code_byte (in_tdata),
    .push      (push),
    .push_rec  (push_rec)
  );

  c816ld_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .stat     (stat)
  );

  c816ld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .rec        (pop_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/c816ld_front.sv @@
// Front end: takes code bytes, decodes opcode length, gathers operands and
// tracks the width flags. Depends on c816ld_pkg.
module c816ld_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c816ld_pkg::cfg_wr_t           cfg_wr,
  input  logic                          byte_fire,
  input  logic [7:0]                    code_byte,
  output logic                          push,
  output c816ld_pkg::instr_rec_t        push_rec
);

  logic [c816ld_pkg::ADDR_W-1:0] cur_addr_r, cur_addr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        rel_r, rel_nxt;
  logic        abs_r, abs_nxt;
  logic [1:0]  wf_r, wf_nxt;
  logic        track_r, track_nxt;
  logic [9:0]  rom;
  logic [1:0]  dlen;

  // Opcode decode from the mode table
  always_comb begin
    rom  = c816ld_pkg::MODE_ROM[code_byte];
    dlen = rom[1:0] + {1'b0, rom[c816ld_pkg::ROM_ACC_BIT] & wf_r[1]}
                    + {1'b0, rom[c816ld_pkg::ROM_IDX_BIT] & wf_r[0]};
  end

  // Build the record of a completing instruction
  always_comb begin
    push_rec = '0;
    push     = 1'b0;
    if (cnt_r == 2'd0) begin
      push_rec.opcode = code_byte;
      push_rec.addr   = cur_addr_r;
      push_rec.oplen  = dlen;
      push_rec.arg    = '0;
      push_rec.rel    = rom[c816ld_pkg::ROM_REL_BIT];
      push_rec.absl   = rom[c816ld_pkg::ROM_ABS_BIT];
      push            = byte_fire && (dlen == 2'd0);
    end else begin
      push_rec.opcode = op_r;
      push_rec.addr   = cur_addr_r;
      push_rec.oplen  = len_r;
      push_rec.rel    = rel_r;
      push_rec.absl   = abs_r;
      unique case (cnt_r)
        2'd1:    push_rec.arg = {16'h0000, code_byte};
        2'd2:    push_rec.arg = {8'h00, code_byte, acc_r[7:0]};
        default: push_rec.arg = {code_byte, acc_r};
      endcase
      push            = byte_fire && (cnt_r == len_r);
    end
  end

  // Next-state: gathering, width flags, configuration
  always_comb begin
    cur_addr_nxt = cur_addr_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    op_nxt       = op_r;
    acc_nxt      = acc_r;
    rel_nxt      = rel_r;
    abs_nxt      = abs_r;
    wf_nxt       = wf_r;
    track_nxt    = track_r;
    if (byte_fire) begin
      if (push) begin
        cnt_nxt      = 2'd0;
        cur_addr_nxt = cur_addr_r + c816ld_pkg::ADDR_W'(push_rec.oplen)
                       + c816ld_pkg::ADDR_W'(1);
        if (track_r && push_rec.opcode == c816ld_pkg::OP_REP) begin
          wf_nxt = wf_r | push_rec.arg[5:4];
        end else if (track_r && push_rec.opcode == c816ld_pkg::OP_SEP) begin
          wf_nxt = wf_r & ~push_rec.arg[5:4];
        end
      end else if (cnt_r == 2'd0) begin
        op_nxt  = code_byte;
        len_nxt = dlen;
        rel_nxt = rom[c816ld_pkg::ROM_REL_BIT];
        abs_nxt = rom[c816ld_pkg::ROM_ABS_BIT];
        acc_nxt = '0;
        cnt_nxt = 2'd1;
      end else begin
        acc_nxt = push_rec.arg[15:0];
        cnt_nxt = cnt_r + 2'd1;
      end
    end
    if (cfg_wr.valid) begin
      priority case (cfg_wr.index)
        c816ld_pkg::CFG_TRACK_WIDTH: track_nxt    = cfg_wr.data[0];
        c816ld_pkg::CFG_START_ACC:   wf_nxt[1]    = cfg_wr.data[0];
        c816ld_pkg::CFG_START_IDX:   wf_nxt[0]    = cfg_wr.data[0];
        c816ld_pkg::CFG_START_ADDR:  cur_addr_nxt = cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_addr_r <= '0;
      cnt_r      <= '0;
      wf_r       <= '0;
      track_r    <= 1'b1;
    end else begin
      cur_addr_r <= cur_addr_nxt;
      cnt_r      <= cnt_nxt;
      wf_r       <= wf_nxt;
      track_r    <= track_nxt;
    end
  end

  // Held opcode and operand bytes
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    rel_r <= rel_nxt;
    abs_r <= abs_nxt;
  end

`ifndef SYNTHESIS
  // A started instruction never counts past its operand length
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> (cnt_r <= len_r))
    else $error("operand byte count beyond length");
`endif

endmodule

@@ sv/c816ld_fifo.sv @@
// Small register queue of completed instruction records between front and back.
// Depends on c816ld_pkg.
module c816ld_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  c816ld_pkg::instr_rec_t push_rec,
  input  logic                   pop,
  output c816ld_pkg::instr_rec_t pop_rec,
  output c816ld_pkg::q_stat_t    stat
);

  c816ld_pkg::instr_rec_t           mem [c816ld_pkg::QDEPTH];
  logic [c816ld_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [c816ld_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [c816ld_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  // Status and read side
  always_comb begin
    stat.full  = (cnt_r == c816ld_pkg::QCNT_W'(c816ld_pkg::QDEPTH));
    stat.empty = (cnt_r == '0);
    pop_rec    = mem[rd_ptr_r];
  end

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == c816ld_pkg::QPTR_W'(c816ld_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + c816ld_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == c816ld_pkg::QPTR_W'(c816ld_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + c816ld_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + c816ld_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - c816ld_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && stat.full) |-> pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= c816ld_pkg::QCNT_W'(c816ld_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ sv/c816ld_back.sv @@
// Back end: computes the branch or absolute target of each queued instruction
// and holds the result in the output register. Depends on c816ld_pkg.
module c816ld_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  c816ld_pkg::q_stat_t                 stat,
  input  c816ld_pkg::instr_rec_t              rec,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [c816ld_pkg::ODATA_W-1:0]      out_tdata,
  output logic                                out_tuser
);

  logic                               valid_r, valid_nxt;
  logic [c816ld_pkg::ODATA_W-1:0]     data_r;
  logic                               has_r;
  logic [15:0]                        rel_sum;
  logic [15:0]                        sext;
  logic                               has;
  logic [c816ld_pkg::ADDR_W-1:0]      tgt;
  logic [2:0]                         ilen;

  // Target computation
  always_comb begin
    sext    = (rec.oplen == 2'd1 && rec.arg[7]) ? 16'hFF00 : 16'h0000;
    rel_sum = rec.addr[15:0] + 16'(rec.oplen) + 16'd1 + rec.arg[15:0] + sext;
    has     = (rec.oplen != 2'd0) && (rec.rel || rec.absl);
    ilen    = 3'(rec.oplen) + 3'd1;
    if (rec.oplen == 2'd0) begin
      tgt = '0;
    end else if (rec.rel) begin
      tgt = {8'h00, rel_sum};
    end else if (rec.absl) begin
      tgt = rec.arg;
    end else begin
      tgt = '0;
    end
  end

  // Output register handshake
  always_comb begin
    pop       = !stat.empty && (!valid_r || out_tready);
    valid_nxt = pop ? 1'b1 : (valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= {5'b00000, tgt, rec.arg, ilen, rec.addr, rec.opcode};
      has_r  <= has;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = has_r;

endmodule
